// ===== sv/csem_pkg.sv =====
// Shared types and constants for the counting semaphore bank.
`default_nettype none

package csem_pkg;

	localparam int SEM_COUNT = 16;
	localparam int ID_W      = 4;
	localparam int PID_W     = 5;
	localparam int COUNT_W   = 8;
	localparam int NEXT_ID_W = $clog2(SEM_COUNT + 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_LOCK   = 2'd1,
		OP_UNLOCK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_ID      = 2'd1,
		ST_QUEUE_FULL = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [ID_W-1:0]    sem_id;
		logic [COUNT_W-1:0] initial_count;
		logic [PID_W-1:0]   caller_pid;
	} req_word_t;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  created_id;
		logic             caller_blocked;
		logic             wake_valid;
		logic [PID_W-1:0] wake_pid;
	} rsp_word_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== sv/counting_semaphore_with_wait_queues.sv =====
// Top level of the counting semaphore bank with per-semaphore FIFO wait queues.
//
//   channel  dir  handshake              word
//   req      in   req_valid / req_stall  req_word  (op, sem_id, initial_count, caller_pid)
//   rsp      out  rsp_valid / rsp_stall  rsp_word  (status, created_id, caller_blocked,
//                                                   wake_valid, wake_pid)
//
// Each word is captured in IDLE, which also reads the wait store; in EXEC, once rsp is
// free, it updates the semaphore state and loads the response register. The registered
// read of the wait-store RAM is why the store is read at capture.
// Reset clears counts, queue pointers and the free-id counter at once; the wait store
// is not cleared and there is no clearing pass.
// A new req word is taken while a response waits; the update holds until rsp is free.
`default_nettype none

module counting_semaphore_with_wait_queues
	import csem_pkg::*;
#(
	parameter int WAIT_DEPTH = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req_word,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp_word
);

	dp_cmd_t cmd;

	csem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	csem_dp #(
		.WAIT_DEPTH (WAIT_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_word (req_word),
		.rsp_word (rsp_word)
	);

endmodule

`default_nettype wire

// ===== sv/csem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module csem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/csem_ctrl.sv =====
// Controller: accepts one request word, then commits it when the response register is free.
`default_nettype none

module csem_ctrl
	import csem_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	output dp_cmd_t      cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        rsp_valid_q;
	logic        rsp_free;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (rsp_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			S_EXEC: begin
				cmd.commit = rsp_free;
			end
			default: ;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold the response valid until the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (req_stall && state_q == S_EXEC))
		else $error("request accepted but controller did not go busy");

	a_commit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(rsp_valid_q && rsp_stall))
		else $error("commit while response register is blocked");

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> rsp_valid)
		else $error("stalled response word dropped");
`endif

endmodule

`default_nettype wire

// ===== sv/csem_dp.sv =====
// Datapath: per-semaphore counts and wait-queue pointers, free-id counter, wait store RAM.
`default_nettype none

module csem_dp
	import csem_pkg::*;
#(
	parameter int WAIT_DEPTH = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dp_cmd_t   cmd,
	input  wire req_word_t req_word,
	output rsp_word_t      rsp_word
);

	localparam int PTR_W       = $clog2(WAIT_DEPTH);
	localparam int SIZE_W      = $clog2(WAIT_DEPTH + 1);
	localparam int STORE_DEPTH = SEM_COUNT * WAIT_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	req_word_t              item_q;
	rsp_word_t              rsp_q;
	rsp_word_t              rsp_nxt;
	logic [COUNT_W-1:0]     cnt_q  [SEM_COUNT];
	logic [PTR_W-1:0]       head_q [SEM_COUNT];
	logic [PTR_W-1:0]       tail_q [SEM_COUNT];
	logic [SIZE_W-1:0]      size_q [SEM_COUNT];
	logic [NEXT_ID_W-1:0]   next_id_q;

	logic [ID_W-1:0]        sel_sid;
	logic [COUNT_W-1:0]     cur_cnt;
	logic [PTR_W-1:0]       cur_head;
	logic [PTR_W-1:0]       cur_tail;
	logic [SIZE_W-1:0]      cur_size;

	logic                   upd_en;
	logic [ID_W-1:0]        upd_sid;
	logic [COUNT_W-1:0]     nxt_cnt;
	logic [PTR_W-1:0]       nxt_head;
	logic [PTR_W-1:0]       nxt_tail;
	logic [SIZE_W-1:0]      nxt_size;
	logic                   take_id;
	logic                   push;

	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [ADDR_W-1:0]      rd_addr;
	logic [PID_W-1:0]       rd_pid;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [ID_W-1:0] sid,
			input logic [PTR_W-1:0] ptr);
		return ADDR_W'(sid) * ADDR_W'(WAIT_DEPTH) + ADDR_W'(ptr);
	endfunction

	// Read the addressed semaphore: the incoming word on capture, the held word otherwise
	assign sel_sid  = cmd.capture ? req_word.sem_id : item_q.sem_id;
	assign cur_cnt  = cnt_q[sel_sid];
	assign cur_head = head_q[sel_sid];
	assign cur_tail = tail_q[sel_sid];
	assign cur_size = size_q[sel_sid];

	// Fetch the oldest waiter while the word is captured
	assign rd_addr = slot_addr(req_word.sem_id, cur_head);
	assign wr_en   = cmd.commit && push;
	assign wr_addr = slot_addr(item_q.sem_id, cur_tail);

	csem_ram #(
		.WIDTH (PID_W),
		.DEPTH (STORE_DEPTH)
	) u_wait_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (item_q.caller_pid),
		.rd_en   (cmd.capture),
		.rd_addr (rd_addr),
		.rd_data (rd_pid)
	);

	// Decide the operation's effect and its response word
	always_comb begin
		rsp_nxt        = '0;
		rsp_nxt.status = ST_OK;
		upd_en         = 1'b0;
		upd_sid        = item_q.sem_id;
		nxt_cnt        = cur_cnt;
		nxt_head       = cur_head;
		nxt_tail       = cur_tail;
		nxt_size       = cur_size;
		take_id        = 1'b0;
		push           = 1'b0;
		case (item_q.op)
			OP_CREATE: begin
				if (next_id_q == NEXT_ID_W'(SEM_COUNT)) begin
					rsp_nxt.status = ST_NO_ID;
				end else begin
					take_id            = 1'b1;
					upd_en             = 1'b1;
					upd_sid            = next_id_q[ID_W-1:0];
					nxt_cnt            = item_q.initial_count;
					nxt_head           = '0;
					nxt_tail           = '0;
					nxt_size           = '0;
					rsp_nxt.created_id = next_id_q[ID_W-1:0];
				end
			end
			OP_LOCK: begin
				if (cur_cnt != '0) begin
					upd_en  = 1'b1;
					nxt_cnt = cur_cnt - 1'b1;
				end else if (cur_size == SIZE_W'(WAIT_DEPTH)) begin
					rsp_nxt.status = ST_QUEUE_FULL;
				end else begin
					push                   = 1'b1;
					upd_en                 = 1'b1;
					nxt_tail               = wrap_next(cur_tail);
					nxt_size               = cur_size + 1'b1;
					rsp_nxt.caller_blocked = 1'b1;
				end
			end
			OP_UNLOCK: begin
				if (cur_size == '0) begin
					// saturate the count at its maximum
					if (cur_cnt != COUNT_MAX) begin
						upd_en  = 1'b1;
						nxt_cnt = cur_cnt + 1'b1;
					end
				end else begin
					upd_en             = 1'b1;
					nxt_head           = wrap_next(cur_head);
					nxt_size           = cur_size - 1'b1;
					rsp_nxt.wake_valid = 1'b1;
					rsp_nxt.wake_pid   = rd_pid;
				end
			end
			default: ;
		endcase
	end

	// Capture the request word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req_word;
		end
	end

	// Load the response word
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_word = rsp_q;

	// Update per-semaphore state on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SEM_COUNT; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
				size_q[i] <= '0;
			end
		end else if (cmd.commit && upd_en) begin
			cnt_q[upd_sid]  <= nxt_cnt;
			head_q[upd_sid] <= nxt_head;
			tail_q[upd_sid] <= nxt_tail;
			size_q[upd_sid] <= nxt_size;
		end
	end

	// Advance the free-id counter; ids are never returned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= '0;
		end else if (cmd.commit && take_id) begin
			next_id_q <= next_id_q + 1'b1;
		end
	end

`ifndef SYNTH
	a_id_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q <= NEXT_ID_W'(SEM_COUNT))
		else $error("free-id counter ran past the semaphore count");

	a_id_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (next_id_q >= $past(next_id_q)))
		else $error("free-id counter moved back");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && upd_en) |-> (nxt_size <= SIZE_W'(WAIT_DEPTH)))
		else $error("wait queue size exceeds its depth");
`endif

endmodule

`default_nettype wire
